// ===== hw/rtl/ksm_pkg.sv =====
package ksm_pkg;

  localparam int KNOB_W    = 6;
  localparam int SAMPLE_W  = 8;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int VALUE_W   = 10;
  localparam int COPY_W    = 9;

  localparam int KNOB_COUNT_DEF = 44;
  localparam int BANK_WIDTH     = 8;
  localparam int BANK_AW        = $clog2(BANK_WIDTH);
  localparam int BANK_COUNT     = 5;
  localparam int TEMPO_KNOB     = 42;
  localparam int TEMPO_OFFSET   = 30;
  localparam int LEVEL_OFFSET   = 70;
  localparam int PITCH_FLIP     = 128;

  // floor(v*16/51) == (v*LEVEL_MUL) >> LEVEL_SHIFT for every 8-bit v
  localparam int LEVEL_MUL   = 20561;
  localparam int LEVEL_MUL_W = 15;
  localparam int LEVEL_SHIFT = 16;
  localparam int LEVEL_Q_W   = 7;

  localparam int KIND_COUNT = 6;
  localparam int COPY_DEPTH = KIND_COUNT * (1 << SLOT_W);

  localparam logic [KNOB_W-BANK_AW-1:0] BANK_LEVEL = 3'd0;
  localparam logic [KNOB_W-BANK_AW-1:0] BANK_PITCH = 3'd1;
  localparam logic [KNOB_W-BANK_AW-1:0] BANK_GAIN  = 3'd2;
  localparam logic [KNOB_W-BANK_AW-1:0] BANK_TIME  = 3'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_OUT_LEVEL = 3'd0,
    KIND_PITCH     = 3'd1,
    KIND_ENV_GAIN  = 3'd2,
    KIND_ENV_TIME  = 3'd3,
    KIND_TRACK_VOL = 3'd4,
    KIND_TEMPO     = 3'd5
  } param_kind_t;

  typedef struct packed {
    logic              act;
    param_kind_t       kind;
    logic [SLOT_W-1:0] slot;
  } knob_dec_t;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] level;
    logic signed [VALUE_W-1:0]  value;
  } upd_t;

  function automatic knob_dec_t decode_knob(logic [KNOB_W-1:0] knob, logic upper);
    knob_dec_t                  d;
    logic [BANK_AW-1:0]         outn;
    logic [KNOB_W-BANK_AW-1:0]  bank;
    d.act  = 1'b0;
    d.kind = KIND_OUT_LEVEL;
    d.slot = '0;
    outn   = knob[BANK_AW-1:0];
    bank   = knob[KNOB_W-1:BANK_AW];
    if (knob < KNOB_W'(BANK_COUNT * BANK_WIDTH)) begin
      d.act = 1'b1;
      case (bank)
        BANK_LEVEL: begin
          d.kind = KIND_OUT_LEVEL;
          d.slot = {1'b0, outn};
        end
        BANK_PITCH: begin
          d.kind = KIND_PITCH;
          d.slot = {1'b0, outn};
        end
        BANK_GAIN: begin
          d.kind = KIND_ENV_GAIN;
          d.slot = {upper, outn};
        end
        BANK_TIME: begin
          d.kind = KIND_ENV_TIME;
          d.slot = {upper, outn};
        end
        default: begin
          d.kind = KIND_TRACK_VOL;
          d.slot = {upper, outn};
        end
      endcase
    end else if (knob == KNOB_W'(TEMPO_KNOB)) begin
      d.act  = 1'b1;
      d.kind = KIND_TEMPO;
      d.slot = '0;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/ksm_if.sv =====
interface ksm_in_if;
  import ksm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KNOB_W-1:0]   knob_number;
  logic [SAMPLE_W-1:0] raw_sample;
  logic                upper_track_bank;

  modport source (output valid, output knob_number, output raw_sample,
                  output upper_track_bank, input ready);
  modport sink   (input valid, input knob_number, input raw_sample,
                  input upper_track_bank, output ready);
endinterface

interface ksm_out_if;
  import ksm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        param_kind;
  logic [SLOT_W-1:0]        slot;
  logic signed [VALUE_W-1:0] param_value;

  modport source (output valid, output param_kind, output slot, output param_value,
                  input ready);
  modport sink   (input valid, input param_kind, input slot, input param_value,
                  output ready);
endinterface

// ===== hw/rtl/ksm_ram.sv =====
module ksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ksm_upd.sv =====
module ksm_upd (
  input  logic [ksm_pkg::SAMPLE_W-1:0] old_level,
  input  logic [ksm_pkg::SAMPLE_W-1:0] sample,
  input  ksm_pkg::param_kind_t         kind,
  output ksm_pkg::upd_t                res
);
  import ksm_pkg::*;

  localparam int PROD_W = SAMPLE_W + LEVEL_MUL_W;

  logic signed [VALUE_W-1:0]  diff;
  logic signed [VALUE_W-1:0]  diff_adj;
  logic signed [VALUE_W-1:0]  half;
  logic        [VALUE_W-1:0]  sum;
  logic        [SAMPLE_W-1:0] lvl;
  logic        [PROD_W-1:0]   prod;
  logic        [LEVEL_Q_W-1:0] quot;
  logic        [VALUE_W-1:0]  level_val;

  // halve toward zero
  assign diff     = $signed({2'b00, sample}) - $signed({2'b00, old_level});
  assign diff_adj = diff + $signed(VALUE_W'(diff[VALUE_W-1]));
  assign half     = diff_adj >>> 1;
  assign sum      = {2'b00, old_level} + half;
  assign lvl      = sum[SAMPLE_W-1:0];

  assign prod      = PROD_W'(lvl) * PROD_W'(LEVEL_MUL);
  assign quot      = prod[LEVEL_SHIFT +: LEVEL_Q_W];
  assign level_val = VALUE_W'(quot) - VALUE_W'(LEVEL_OFFSET);

  always_comb begin
    res.level = lvl;
    case (kind)
      KIND_OUT_LEVEL, KIND_ENV_GAIN, KIND_TRACK_VOL: res.value = level_val;
      KIND_PITCH:    res.value = VALUE_W'(lvl ^ SAMPLE_W'(PITCH_FLIP));
      KIND_ENV_TIME: res.value = VALUE_W'(lvl);
      KIND_TEMPO:    res.value = VALUE_W'(lvl) + VALUE_W'(TEMPO_OFFSET);
      default:       res.value = VALUE_W'(lvl);
    endcase
  end

endmodule

// ===== hw/rtl/knob_smooth_map_change_detect.sv =====
// channel | dir | handshake   | payload
// in_chan | in  | valid/ready | knob_number[6], raw_sample[8], upper_track_bank[1]
// out_chan| out | valid/ready | param_kind[3], slot[4], param_value[10] signed
//
// one request per cycle unless out_chan stalls; each result passes stage 1, then the output register
// level and copy memories are read at accept and written back when stage 1 fires,
// each with a one-entry bypass for a back-to-back hit on the same entry
// reset clears the valid bits of both memories, no clearing pass is needed
// a stalled output register holds the second stage, which then holds in_chan
module knob_smooth_map_change_detect #(
  parameter int KNOB_COUNT = ksm_pkg::KNOB_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ksm_in_if.sink    in_chan,
  ksm_out_if.source out_chan
);
  import ksm_pkg::*;

  localparam int KA  = $clog2(KNOB_COUNT);
  localparam int CAW = $clog2(COPY_DEPTH);

  logic                in_ready;
  logic                in_fire;
  logic [KNOB_W-1:0]   knob_m;
  knob_dec_t           dec;
  logic [KA-1:0]       sm_raddr;
  logic [CAW-1:0]      cp_raddr;

  logic                s1_valid_r, s1_valid_nxt;
  logic [KA-1:0]       s1_addr_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  knob_dec_t           s1_dec_r;
  logic                s1_smv_r;
  logic                s1_cpv_r;
  logic                s1_fire;
  logic [CAW-1:0]      s1_cp_addr;

  logic [KNOB_COUNT-1:0] sm_vld_r;
  logic [COPY_DEPTH-1:0] cp_vld_r;

  logic [SAMPLE_W-1:0] sm_rdata;
  logic [COPY_W-1:0]   cp_rdata;
  logic [SAMPLE_W-1:0] old_level;
  logic [COPY_W-1:0]   old_copy;
  upd_t                upd;
  logic                changed;
  logic                cp_we;

  logic                sm_byp_v_r;
  logic [KA-1:0]       sm_byp_addr_r;
  logic [SAMPLE_W-1:0] sm_byp_data_r;
  logic                cp_byp_v_r;
  logic [CAW-1:0]      cp_byp_addr_r;
  logic [COPY_W-1:0]   cp_byp_data_r;

  logic                      out_valid_r, out_valid_nxt;
  param_kind_t               out_kind_r;
  logic [SLOT_W-1:0]         out_slot_r;
  logic signed [VALUE_W-1:0] out_value_r;

  // request side
  assign in_fire = in_chan.valid & in_ready;
  assign in_chan.ready = in_ready;

  always_comb begin
    if ({1'b0, in_chan.knob_number} >= (KNOB_W + 1)'(KNOB_COUNT)) begin
      knob_m = in_chan.knob_number - KNOB_W'(KNOB_COUNT);
    end else begin
      knob_m = in_chan.knob_number;
    end
  end

  assign dec      = decode_knob(knob_m, in_chan.upper_track_bank);
  assign sm_raddr = knob_m[KA-1:0];
  assign cp_raddr = CAW'({dec.kind, dec.slot});

  ksm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (KNOB_COUNT)
  ) u_level_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (upd.level),
    .re    (in_fire),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  ksm_ram #(
    .WIDTH (COPY_W),
    .DEPTH (COPY_DEPTH)
  ) u_copy_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (s1_cp_addr),
    .wdata (upd.value[COPY_W-1:0]),
    .re    (in_fire),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

  // stage 1: modify and write back
  assign s1_fire    = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_ready   = ~s1_valid_r | s1_fire;
  assign s1_cp_addr = CAW'({s1_dec_r.kind, s1_dec_r.slot});

  always_comb begin
    if (sm_byp_v_r && sm_byp_addr_r == s1_addr_r) begin
      old_level = sm_byp_data_r;
    end else if (s1_smv_r) begin
      old_level = sm_rdata;
    end else begin
      old_level = '0;
    end
    if (cp_byp_v_r && cp_byp_addr_r == s1_cp_addr) begin
      old_copy = cp_byp_data_r;
    end else if (s1_cpv_r) begin
      old_copy = cp_rdata;
    end else begin
      old_copy = '0;
    end
  end

  ksm_upd u_upd (
    .old_level (old_level),
    .sample    (s1_sample_r),
    .kind      (s1_dec_r.kind),
    .res       (upd)
  );

  assign changed = s1_dec_r.act & (old_copy != upd.value[COPY_W-1:0]);
  assign cp_we   = s1_fire & changed;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? changed : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sm_byp_v_r  <= 1'b0;
      cp_byp_v_r  <= 1'b0;
      sm_vld_r    <= '0;
      cp_vld_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        sm_byp_v_r          <= 1'b1;
        sm_vld_r[s1_addr_r] <= 1'b1;
      end
      if (cp_we) begin
        cp_byp_v_r           <= 1'b1;
        cp_vld_r[s1_cp_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r   <= sm_raddr;
      s1_sample_r <= in_chan.raw_sample;
      s1_dec_r    <= dec;
      s1_smv_r    <= sm_vld_r[sm_raddr];
      s1_cpv_r    <= cp_vld_r[cp_raddr];
    end
    if (s1_fire) begin
      sm_byp_addr_r <= s1_addr_r;
      sm_byp_data_r <= upd.level;
      out_kind_r    <= s1_dec_r.kind;
      out_slot_r    <= s1_dec_r.slot;
      out_value_r   <= upd.value;
    end
    if (cp_we) begin
      cp_byp_addr_r <= s1_cp_addr;
      cp_byp_data_r <= upd.value[COPY_W-1:0];
    end
  end

  // result side
  assign out_chan.valid       = out_valid_r;
  assign out_chan.param_kind  = out_kind_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.param_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire))
    else $error("result appeared without a stage-1 update");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("request side stalled without a blocked result");

  a_tempo_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_TEMPO) |-> (out_slot_r == '0))
    else $error("tempo result with nonzero slot");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_OUT_LEVEL || out_kind_r == KIND_ENV_GAIN ||
     out_kind_r == KIND_TRACK_VOL))
    |-> (out_value_r >= -VALUE_W'(LEVEL_OFFSET) && out_value_r <= 10'sd10))
    else $error("level result out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ksm_pkg::*;

  localparam int N_ITEMS   = 1300;
  localparam int WDOG_MAX  = 1000;
  localparam int DRAIN     = 10;
  localparam int HOLD_LEN  = 80;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic [KNOB_W-1:0]   knob;
    logic [SAMPLE_W-1:0] sample;
    logic                upper;
  } knob_sample_t;

  typedef struct packed {
    param_kind_t         kind;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  value;
  } param_update_t;

  logic clk;
  logic rst_n;

  ksm_in_if  in_chan();
  ksm_out_if out_chan();

  knob_smooth_map_change_detect i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  logic [SAMPLE_W-1:0]      smooth_mem [KNOB_COUNT_DEF];
  logic signed [7:0]        out_level_copy [8];
  logic [7:0]               pitch_copy [8];
  logic signed [7:0]        env_gain_copy [16];
  logic [7:0]               env_time_copy [16];
  logic signed [7:0]        track_vol_copy [16];
  logic [COPY_W-1:0]        tempo_copy;

  knob_sample_t  sample_queue [$];
  param_update_t expected_updates [$];

  knob_sample_t  cur_sample;
  knob_sample_t  next_sample;
  param_update_t got_update;
  param_update_t want;

  int n_total;
  int n_accepted;
  int n_updates;
  int n_fail;
  int cycle_count;
  int idle_cycles;
  int send_gap;
  int stall_left;
  int hold_left;
  int hold_seen;
  bit hold_done;
  int kind_hits [KIND_COUNT];

  function automatic void push_update(param_kind_t kind, logic [SLOT_W-1:0] slot, int value);
    param_update_t u;
    u.kind  = kind;
    u.slot  = slot;
    u.value = VALUE_W'(value);
    expected_updates.push_back(u);
  endfunction

  function automatic void predict_knob_update(knob_sample_t s);
    int                 knob;
    int                 old;
    int                 v;
    int                 lvl;
    int                 m;
    int                 bank;
    logic [BANK_AW-1:0] outn;
    logic [SLOT_W-1:0]  trk;
    knob = int'(s.knob) % KNOB_COUNT_DEF;
    old  = int'(smooth_mem[knob]);
    v    = (old + (int'(s.sample) - old) / 2) & 255;
    smooth_mem[knob] = SAMPLE_W'(v);
    lvl  = (v * 16) / 51 - LEVEL_OFFSET;
    if (knob < BANK_COUNT * BANK_WIDTH) begin
      bank = knob / BANK_WIDTH;
      outn = BANK_AW'(knob % BANK_WIDTH);
      trk  = {s.upper, outn};
      case (bank)
        BANK_LEVEL: begin
          if (int'(out_level_copy[outn]) != lvl) begin
            out_level_copy[outn] = 8'(lvl);
            push_update(KIND_OUT_LEVEL, {1'b0, outn}, lvl);
          end
        end
        BANK_PITCH: begin
          m = v ^ PITCH_FLIP;
          if (pitch_copy[outn] != 8'(m)) begin
            pitch_copy[outn] = 8'(m);
            push_update(KIND_PITCH, {1'b0, outn}, m);
          end
        end
        BANK_GAIN: begin
          if (int'(env_gain_copy[trk]) != lvl) begin
            env_gain_copy[trk] = 8'(lvl);
            push_update(KIND_ENV_GAIN, trk, lvl);
          end
        end
        BANK_TIME: begin
          if (env_time_copy[trk] != 8'(v)) begin
            env_time_copy[trk] = 8'(v);
            push_update(KIND_ENV_TIME, trk, v);
          end
        end
        default: begin
          if (int'(track_vol_copy[trk]) != lvl) begin
            track_vol_copy[trk] = 8'(lvl);
            push_update(KIND_TRACK_VOL, trk, lvl);
          end
        end
      endcase
    end else if (knob == TEMPO_KNOB) begin
      m = (v + TEMPO_OFFSET) & 9'h1FF;
      if (tempo_copy != COPY_W'(m)) begin
        tempo_copy = COPY_W'(m);
        push_update(KIND_TEMPO, '0, m);
      end
    end
  endfunction

  function automatic bit in_calm_tail();
    return n_accepted + CALM_TAIL >= n_total;
  endfunction

  task automatic add_sample(int knob, int sample, bit upper);
    knob_sample_t s;
    s.knob   = KNOB_W'(knob);
    s.sample = SAMPLE_W'(sample);
    s.upper  = upper;
    sample_queue.push_back(s);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        cur_sample.knob   = in_chan.knob_number;
        cur_sample.sample = in_chan.raw_sample;
        cur_sample.upper  = in_chan.upper_track_bank;
        predict_knob_update(cur_sample);
        n_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (!in_calm_tail() && hold_left == 0 && (n_accepted / 200) % 3 != 2 &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 7);
        in_chan.valid <= 1'b0;
      end else begin
        next_sample = sample_queue.pop_front();
        in_chan.knob_number      <= next_sample.knob;
        in_chan.raw_sample       <= next_sample.sample;
        in_chan.upper_track_bank <= next_sample.upper;
        in_chan.valid            <= 1'b1;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got_update.kind  = param_kind_t'(out_chan.param_kind);
        got_update.slot  = out_chan.slot;
        got_update.value = out_chan.param_value;
        n_updates++;
        if (int'(out_chan.param_kind) < KIND_COUNT) kind_hits[out_chan.param_kind]++;
        if (expected_updates.size() == 0) begin
          $error("unexpected update kind %0d slot %0d value %0d",
                 out_chan.param_kind, out_chan.slot, out_chan.param_value);
          n_fail++;
        end else begin
          want = expected_updates.pop_front();
          if (got_update.kind !== want.kind) begin
            $error("param_kind expected %0d actual %0d", want.kind, got_update.kind);
            n_fail++;
          end
          if (got_update.slot !== want.slot) begin
            $error("slot expected %0d actual %0d", want.slot, got_update.slot);
            n_fail++;
          end
          if (got_update.value !== want.value) begin
            $error("param_value expected %0d actual %0d",
                   $signed(want.value), $signed(got_update.value));
            n_fail++;
          end
        end
      end
      if (!hold_done && n_updates >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_seen++;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!in_calm_tail() && (cycle_count / 256) % 4 != 3 &&
                   $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("timeout after %0d cycles without traffic", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int  k;
    int  s;
    int  reps;
    int  sel;
    bit  up;
    rst_n = 1'b0;
    in_chan.valid            = 1'b0;
    in_chan.knob_number      = '0;
    in_chan.raw_sample       = '0;
    in_chan.upper_track_bank = 1'b0;
    out_chan.ready           = 1'b0;
    n_accepted  = 0;
    n_updates   = 0;
    n_fail      = 0;
    cycle_count = 0;
    idle_cycles = 0;
    hold_seen   = 0;
    hold_done   = 1'b0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    foreach (smooth_mem[i]) smooth_mem[i] = '0;
    foreach (out_level_copy[i]) out_level_copy[i] = '0;
    foreach (pitch_copy[i]) pitch_copy[i] = '0;
    foreach (env_gain_copy[i]) env_gain_copy[i] = '0;
    foreach (env_time_copy[i]) env_time_copy[i] = '0;
    foreach (track_vol_copy[i]) track_vol_copy[i] = '0;
    tempo_copy = '0;

    // directed: bank edges, upper flag, unused knobs, wrapped knob numbers
    add_sample(0, 255, 1'b0);
    add_sample(0, 0, 1'b0);
    add_sample(1, 0, 1'b0);
    add_sample(1, 0, 1'b0);
    add_sample(7, 255, 1'b1);
    add_sample(8, 128, 1'b0);
    add_sample(8, 0, 1'b0);
    add_sample(15, 255, 1'b1);
    add_sample(16, 200, 1'b1);
    add_sample(23, 255, 1'b0);
    add_sample(24, 0, 1'b1);
    add_sample(24, 255, 1'b1);
    add_sample(31, 255, 1'b0);
    add_sample(32, 255, 1'b1);
    add_sample(39, 255, 1'b0);
    add_sample(40, 255, 1'b1);
    add_sample(41, 170, 1'b0);
    add_sample(42, 0, 1'b0);
    add_sample(42, 255, 1'b0);
    add_sample(42, 255, 1'b1);
    add_sample(43, 255, 1'b1);
    add_sample(44, 85, 1'b0);
    add_sample(63, 255, 1'b1);
    add_sample(62, 1, 1'b0);

    // random: short runs on one knob so levels settle and repeat
    while (sample_queue.size() < N_ITEMS) begin
      k    = ($urandom_range(0, 9) == 0) ? $urandom_range(44, 63) : $urandom_range(0, 43);
      up   = $urandom_range(0, 1);
      sel  = $urandom_range(0, 9);
      reps = $urandom_range(1, 5);
      s    = $urandom_range(0, 255);
      if (sel < 2) s = 0;
      else if (sel < 4) s = 255;
      repeat (reps) begin
        if (sel == 9) s = $urandom_range(0, 255);
        add_sample(k, s, up);
      end
    end
    n_total = sample_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_queue.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d knob samples, checked %0d updates, receiver held off %0d cycles",
             n_accepted, n_updates, hold_seen);
    $display("updates by kind: level %0d pitch %0d gain %0d time %0d volume %0d tempo %0d",
             kind_hits[KIND_OUT_LEVEL], kind_hits[KIND_PITCH], kind_hits[KIND_ENV_GAIN],
             kind_hits[KIND_ENV_TIME], kind_hits[KIND_TRACK_VOL], kind_hits[KIND_TEMPO]);
    if (n_fail == 0 && expected_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
